// ----- hw/rtl/sorted_array_priority_queue_assert.svh -----
// Assertion macros for the sorted array priority queue.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SAPQ_ASSERT_NOW(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SAPQ_ASSERT_NXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- hw/rtl/sapq_pkg.sv -----
// Package: types and codes of the sorted array priority queue.
`default_nettype none
package sapq_pkg;

	localparam int unsigned DEPTH   = 16;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned ENTRY_W = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic                      opcode;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] removed_value;
		logic [1:0]                status;
		logic [ENTRY_W-1:0]        entry_count;
	} rsp_t;

	// Broadcast to every cell.
	typedef struct packed {
		logic                      ins;
		logic                      rem;
		logic signed [VALUE_W-1:0] value;
	} cell_cmd_t;

	// What a cell shows its neighbors.
	typedef struct packed {
		logic                      occ;
		logic                      gt;
		logic signed [VALUE_W-1:0] data;
	} cell_link_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sapq_cell.sv -----
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`default_nettype none
module sapq_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sapq_pkg::cell_cmd_t  cmd,
	input  sapq_pkg::cell_link_t lft,
	input  sapq_pkg::cell_link_t rgt,
	output sapq_pkg::cell_link_t link
);
	import sapq_pkg::*;

	logic                      occ_q;
	logic signed [VALUE_W-1:0] data_q;
	logic                      occ_d;
	logic signed [VALUE_W-1:0] data_d;
	logic                      gt;

	assign gt = occ_q && ($signed(data_q) > $signed(cmd.value));

	always_comb begin
		occ_d  = occ_q;
		data_d = data_q;
		if (cmd.ins) begin
			if (gt || !occ_q) begin
				if (lft.gt) begin
					data_d = lft.data;
					occ_d  = 1'b1;
				end else if (lft.occ) begin
					data_d = cmd.value;
					occ_d  = 1'b1;
				end
			end
		end else if (cmd.rem) begin
			data_d = rgt.data;
			occ_d  = rgt.occ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign link = '{occ: occ_q, gt: gt, data: data_q};

endmodule
`default_nettype wire

// ----- hw/rtl/sorted_array_priority_queue.sv -----
// A result is registered and shown in the cycle after its transaction is accepted.
// Throughput: one insert or remove per cycle unless a stalled result holds the request;
// every cell of the chain updates in the same cycle, so no operation waits on another.
// Reset clears the occupied bits, the entry count and the output valid;
// entry data is not reset and becomes defined as entries are written.
`default_nettype none
module sorted_array_priority_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_stall,
	input  sapq_pkg::req_t req,
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output sapq_pkg::rsp_t rsp
);
	import sapq_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	cell_cmd_t       cmd;
	cell_link_t      link [DEPTH];
	cell_link_t      lft  [DEPTH];
	cell_link_t      rgt  [DEPTH];
	logic [DEPTH-1:0] occ_vec;
	logic            accept;
	logic            full;
	logic            empty;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_d;
	logic            rsp_valid_q;
	rsp_t            rsp_q;
	rsp_t            rsp_d;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = link[DEPTH-1].occ;
	assign empty     = !link[0].occ;

	assign cmd.ins   = accept && (req.opcode == OP_INSERT) && !full;
	assign cmd.rem   = accept && (req.opcode == OP_REMOVE) && !empty;
	assign cmd.value = req.value;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ_vec[i] = link[i].occ;
			if (i == 0) begin
				lft[i] = '{occ: 1'b1, gt: 1'b0, data: '0};
			end else begin
				lft[i] = link[i-1];
			end
			if (i == DEPTH - 1) begin
				rgt[i] = '{occ: 1'b0, gt: 1'b0, data: '0};
			end else begin
				rgt[i] = link[i+1];
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		sapq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.lft    (lft[g]),
			.rgt    (rgt[g]),
			.link   (link[g])
		);
	end

	always_comb begin
		count_d = count_q;
		if (cmd.ins) begin
			count_d = count_q + CW'(1);
		end else if (cmd.rem) begin
			count_d = count_q - CW'(1);
		end
	end

	always_comb begin
		rsp_d.removed_value = '0;
		rsp_d.status        = ST_OK;
		rsp_d.entry_count   = ENTRY_W'(count_d);
		if (req.opcode == OP_INSERT) begin
			if (full) begin
				rsp_d.status = ST_FULL;
			end
		end else if (empty) begin
			rsp_d.status = ST_EMPTY;
		end else begin
			rsp_d.removed_value = link[0].data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`include "sorted_array_priority_queue_assert.svh"

	`SAPQ_ASSERT_NOW(a_count_matches_cells, 1'b1,
		count_q == CW'($countones(occ_vec)),
		"count disagrees with occupied cells")
	`SAPQ_ASSERT_NOW(a_occ_prefix, 1'b1,
		(occ_vec & (occ_vec + DEPTH'(1))) == '0,
		"occupied cells not contiguous from slot 0")
	`SAPQ_ASSERT_NXT(a_full_reject,
		accept && (req.opcode == OP_INSERT) && full,
		rsp_valid && (rsp.status == ST_FULL) && full,
		"insert into full queue not rejected")
	`SAPQ_ASSERT_NXT(a_remove_shrinks, cmd.rem,
		count_q == $past(count_q) - CW'(1),
		"remove did not shrink the queue")

endmodule
`default_nettype wire

// ----- tb/sorted_array_priority_queue_tb.sv -----
// Testbench for the sorted array priority queue: directed table, then random traffic.
`timescale 1ns / 100ps
module sorted_array_priority_queue_tb;
	import sapq_pkg::*;

	localparam int N_RANDOM    = 1300;
	localparam int IDLE_LIMIT  = 2000;
	localparam int MAX_WAIT    = 11;

	typedef struct {
		logic                      op;
		logic signed [VALUE_W-1:0] val;
		bit                        typed;
		rsp_t                      want;
	} dir_row_t;

	typedef struct {
		bit   typed;
		rsp_t want;
	} pend_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic signed [VALUE_W-1:0] pq_store [DEPTH];
	int                        pq_count = 0;
	rsp_t                      rsp_expect_q [$];
	pend_t                     pend_q [$];
	dir_row_t                  dir_tab [$];
	int                        err_count = 0;
	int unsigned               rsp_seen = 0;
	int unsigned               rsp_seen_last = 0;
	int unsigned               rsp_hold = 0;
	int unsigned               idle_cycles = 0;
	bit                        calm = 1'b0;
	pend_t                     mon_tag;
	rsp_t                      mon_want;

	sorted_array_priority_queue u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// Queue model: ascending store, new value goes after equal entries.
	function automatic rsp_t pq_apply(req_t r);
		rsp_t res;
		int   pos;
		res = '0;
		res.status = ST_OK;
		if (r.opcode == OP_INSERT) begin
			if (pq_count >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				pos = pq_count;
				while (pos > 0 && $signed(pq_store[pos-1]) > $signed(r.value)) begin
					pq_store[pos] = pq_store[pos-1];
					pos--;
				end
				pq_store[pos] = r.value;
				pq_count++;
			end
		end else begin
			if (pq_count == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.removed_value = pq_store[0];
				for (int k = 1; k < pq_count; k++)
					pq_store[k-1] = pq_store[k];
				pq_count--;
			end
		end
		res.entry_count = pq_count[ENTRY_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, rsp_t got, rsp_t want);
		$display("ERROR t=%0t %s: got val=%0d st=%0d cnt=%0d, want val=%0d st=%0d cnt=%0d",
			$realtime, what, got.removed_value, got.status, got.entry_count,
			want.removed_value, want.status, want.entry_count);
		err_count++;
	endtask

	function automatic void add_row(logic op, logic [VALUE_W-1:0] v, bit typed,
			status_t st, logic [VALUE_W-1:0] rv, logic [ENTRY_W-1:0] cnt);
		dir_row_t row;
		row.op = op;
		row.val = v;
		row.typed = typed;
		row.want.removed_value = rv;
		row.want.status = st;
		row.want.entry_count = cnt;
		dir_tab.push_back(row);
	endfunction

	task automatic send_item(logic op, logic [VALUE_W-1:0] v, bit typed, rsp_t want);
		int unsigned gap;
		pend_t       tag;
		gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		tag.typed = typed;
		tag.want = want;
		pend_q.push_back(tag);
		req_valid <= 1'b1;
		req <= '{opcode: op, value: v};
		do @(posedge clk); while (!(req_valid && !req_stall));
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (rsp_expect_q.size() != 0) @(negedge clk);
	endtask

	// Predict on accepted requests, check on accepted results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				mon_tag = pend_q.pop_front();
				mon_want = pq_apply(req);
				rsp_expect_q.push_back(mon_tag.typed ? mon_tag.want : mon_want);
			end
			if (rsp_valid && !rsp_stall) begin
				rsp_seen++;
				if (rsp_expect_q.size() == 0) begin
					report_mismatch("unexpected result", rsp, '0);
				end else begin
					mon_want = rsp_expect_q.pop_front();
					if (rsp.removed_value !== mon_want.removed_value)
						report_mismatch("removed_value", rsp, mon_want);
					if (rsp.status !== mon_want.status)
						report_mismatch("status", rsp, mon_want);
					if (rsp.entry_count !== mon_want.entry_count)
						report_mismatch("entry_count", rsp, mon_want);
				end
			end
		end
	end

	// Receiver: fresh stall count per accepted result.
	always @(negedge clk) begin
		if (rsp_seen != rsp_seen_last) begin
			rsp_seen_last = rsp_seen;
			rsp_hold = calm ? 0 : $urandom_range(0, MAX_WAIT);
		end
		if (!calm && rsp_hold > 0) begin
			rsp_stall <= 1'b1;
			rsp_hold--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int unsigned seg_left;
		int unsigned ins_pct;
		logic        op;
		logic [31:0] v;
		rsp_t        none;

		none = '0;
		add_row(OP_REMOVE, 32'hFFFF_FFFF, 1, ST_EMPTY, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'h7FFF_FFFF, 1, ST_OK, 32'h0, 5'd1);
		add_row(OP_INSERT, 32'h8000_0000, 1, ST_OK, 32'h0, 5'd2);
		add_row(OP_REMOVE, 32'h0, 1, ST_OK, 32'h8000_0000, 5'd1);
		add_row(OP_REMOVE, 32'h0, 1, ST_OK, 32'h7FFF_FFFF, 5'd0);
		add_row(OP_REMOVE, 32'h0, 1, ST_EMPTY, 32'h0, 5'd0);
		// fill to capacity with duplicates and extremes
		add_row(OP_INSERT, 32'd7, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'hFFFF_FFFF, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'd7, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'h8000_0000, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'h7FFF_FFFF, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'd0, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'hFFFF_FFFF, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'd3, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'd7, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'd100, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'hFFFF_FF9C, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'h7FFF_FFFF, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'h8000_0000, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'd5, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'd5, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'd2, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_INSERT, 32'd9, 1, ST_FULL, 32'h0, 5'd16);
		add_row(OP_REMOVE, 32'h0, 0, ST_OK, 32'h0, 5'd0);
		add_row(OP_REMOVE, 32'h5555_AAAA, 0, ST_OK, 32'h0, 5'd0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			send_item(dir_tab[i].op, dir_tab[i].val, dir_tab[i].typed, dir_tab[i].want);

		seg_left = 0;
		ins_pct = 50;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 80);
				ins_pct = $urandom_range(5, 95);
				calm = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 7) == 0)
					drain_results();
			end
			if (n == N_RANDOM / 2)
				drain_results();
			seg_left--;
			op = ($urandom_range(1, 100) <= ins_pct) ? OP_INSERT : OP_REMOVE;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: v = $urandom;
				5, 6:          v = $urandom_range(0, 15) - 8;
				7:             v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				8:             v = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
				default:       v = {$urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 16'($urandom)};
			endcase
			send_item(op, v, 0, none);
		end
		calm = 1'b0;

		drain_results();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
